@@ rtl/stbm_pkg.sv @@
`default_nettype none

package stbm_pkg;

  // Field widths of the item formats.
  localparam int VW   = 10;
  localparam int LW   = 10;
  localparam int OP_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Default store depth.
  localparam int MAX_VERTICES_DEFAULT = 1024;

  // The lockstep climb gives up after this many steps on a malformed tree.
  localparam int CLIMB_LIMIT = 1024;
  localparam int STEP_W      = $clog2(CLIMB_LIMIT + 1);

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [VW-1:0]   vertex_a;
    logic [VW-1:0]   vertex_b;
    logic [VW-1:0]   parent_in;
    logic [LW-1:0]   level_in;
  } stbm_cmd_t;

  typedef struct packed {
    logic          tree_edge;
    logic          bridge_flag;
    logic [VW-1:0] parent_out;
    logic [VW-1:0] common_ancestor;
    logic [VW-1:0] base_first;
    logic [VW-1:0] base_second;
  } stbm_rsp_t;

endpackage

`default_nettype wire

@@ rtl/stbm_if.sv @@
`default_nettype none

// Input item channel.
interface stbm_cmd_if import stbm_pkg::*; ();
  logic      valid;
  logic      ready;
  stbm_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result item channel.
interface stbm_rsp_if import stbm_pkg::*; ();
  logic      valid;
  logic      ready;
  stbm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/spanning_tree_bridge_marker_core.sv @@
`default_nettype none

// Bridge marker over a stored BFS spanning tree. Every accepted item gives exactly one result
// item. A load item writes a vertex's parent and level and clears its cycle mark; a query
// item reports whether the edge from a vertex to its parent is a bridge; an edge item either
// reports a tree edge or climbs both endpoints toward their lowest common ancestor, marking
// each vertex passed, and reports the ancestor and the two base vertices. The block works on
// one item at a time through a small sequencer around a single read port of the tree memory.
// A non-tree edge takes longer the higher the lockstep climb runs, since each step up re-reads
// both vertices through the one memory port. After reset the cycle marks are cleared in a pass
// over every entry before the first item is taken. A result waiting on the output does not hold
// off the next input item, but that item's own result then waits until the earlier one is taken.
module spanning_tree_bridge_marker_core import stbm_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  stbm_cmd_if.sink   cmd,
  stbm_rsp_if.source rsp
);

  localparam int AW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int IW = (AW > VW) ? AW : VW;
  localparam int PW = VW + LW;

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_Q_RD   = 4'd3;
  localparam logic [3:0] ST_Q_EVAL = 4'd4;
  localparam logic [3:0] ST_E_RU   = 4'd5;
  localparam logic [3:0] ST_E_RV   = 4'd6;
  localparam logic [3:0] ST_E_CAP  = 4'd7;
  localparam logic [3:0] ST_E_TREE = 4'd8;
  localparam logic [3:0] ST_E_LVL2 = 4'd9;
  localparam logic [3:0] ST_E_LOOP = 4'd10;
  localparam logic [3:0] ST_E_MV   = 4'd11;
  localparam logic [3:0] ST_E_FIN  = 4'd12;
  localparam logic [3:0] ST_EMIT   = 4'd13;

  // Where the sequencer goes once both vertices have been fetched.
  localparam logic [1:0] PH_INIT = 2'd0;
  localparam logic [1:0] PH_V    = 2'd1;
  localparam logic [1:0] PH_LOOP = 2'd2;

  function automatic logic vtx_ok(input logic [VW-1:0] x);
    return 32'(x) < 32'(MAX_VERTICES);
  endfunction

  function automatic logic [AW-1:0] vtx_addr(input logic [VW-1:0] x);
    logic [IW-1:0] w;
    w = IW'(x);
    return w[AW-1:0];
  endfunction

  logic [3:0]      state;
  logic [1:0]      phase;
  logic [AW-1:0]   clr_cnt;
  logic [STEP_W-1:0] steps;

  logic [VW-1:0] u;
  logic [VW-1:0] v;
  logic [VW-1:0] p_r;
  logic [LW-1:0] l_r;
  logic [VW-1:0] pu;
  logic [VW-1:0] pv;
  logic [LW-1:0] lu;
  logic [LW-1:0] lv;

  logic          res_tree;
  logic          res_bridge;
  logic [VW-1:0] res_par;
  logic [VW-1:0] res_ca;
  logic [VW-1:0] res_bf;
  logic [VW-1:0] res_bs;

  logic      out_valid;
  stbm_rsp_t out_data;

  // Tree memory holds parent and level side by side; marks sit in their own memory.
  logic [PW-1:0] pl_mem [MAX_VERTICES];
  logic          mk_mem [MAX_VERTICES];
  logic [PW-1:0] pl_q;
  logic          mk_q;
  logic          rd_ok_q;

  logic [VW-1:0] rd_vtx;
  logic          pl_we;
  logic          mk_we;
  logic          mk_wdata;
  logic [AW-1:0] mk_waddr;

  logic [VW-1:0] q_par;
  logic [LW-1:0] q_lvl;
  logic          q_mark;
  logic          is_tree;
  logic          climb;

  assign cmd.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // A vertex beyond the store reads as parent zero, level zero and unmarked.
  assign q_par  = rd_ok_q ? pl_q[PW-1:LW] : '0;
  assign q_lvl  = rd_ok_q ? pl_q[LW-1:0] : '0;
  assign q_mark = rd_ok_q & mk_q;

  assign is_tree = (pu == v) || (pv == u);
  assign climb   = (pu != pv) && (steps < STEP_W'(CLIMB_LIMIT));

  // The second fetch of a pair reads the second vertex; every other read uses the first.
  assign rd_vtx = (state == ST_E_RV) ? v : u;
  assign pl_we  = (state == ST_LOAD) && vtx_ok(u);

  // Mark write port: clearing pass, load clear, and marks set along the climb.
  always_comb begin
    mk_we    = 1'b0;
    mk_wdata = 1'b1;
    mk_waddr = vtx_addr(u);
    case (state)
      ST_CLEAR: begin
        mk_we    = 1'b1;
        mk_wdata = 1'b0;
        mk_waddr = clr_cnt;
      end
      ST_LOAD: begin
        mk_we    = vtx_ok(u);
        mk_wdata = 1'b0;
      end
      ST_E_TREE: begin
        mk_we    = !is_tree && (lu < lv) && vtx_ok(v);
        mk_waddr = vtx_addr(v);
      end
      ST_E_LVL2: begin
        mk_we = (lv < lu) && vtx_ok(u);
      end
      ST_E_LOOP: begin
        mk_we = vtx_ok(u);
      end
      ST_E_MV, ST_E_FIN: begin
        mk_we    = vtx_ok(v);
        mk_waddr = vtx_addr(v);
      end
      default: begin
        mk_we = 1'b0;
      end
    endcase
  end

  // Memory ports with registered read data.
  always_ff @(posedge clk) begin
    pl_q    <= pl_mem[vtx_addr(rd_vtx)];
    mk_q    <= mk_mem[vtx_addr(rd_vtx)];
    rd_ok_q <= vtx_ok(rd_vtx);
    if (pl_we) begin
      pl_mem[vtx_addr(u)] <= {p_r, l_r};
    end
    if (mk_we) begin
      mk_mem[mk_waddr] <= mk_wdata;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // The emit step refills the result register itself.
      if (out_valid && rsp.ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.valid) begin
            u          <= cmd.data.vertex_a;
            v          <= cmd.data.vertex_b;
            p_r        <= cmd.data.parent_in;
            l_r        <= cmd.data.level_in;
            steps      <= '0;
            phase      <= PH_INIT;
            res_tree   <= 1'b0;
            res_bridge <= 1'b0;
            res_par    <= '0;
            res_ca     <= '0;
            res_bf     <= '0;
            res_bs     <= '0;
            case (cmd.data.operation)
              OP_LOAD:  state <= ST_LOAD;
              OP_EDGE:  state <= ST_E_RU;
              OP_QUERY: state <= ST_Q_RD;
              default:  state <= ST_EMIT;
            endcase
          end
        end
        ST_LOAD: begin
          state <= ST_EMIT;
        end
        ST_Q_RD: begin
          state <= ST_Q_EVAL;
        end
        ST_Q_EVAL: begin
          res_par    <= q_par;
          res_bridge <= (q_par != u) && !q_mark;
          state      <= ST_EMIT;
        end
        ST_E_RU: begin
          state <= ST_E_RV;
        end
        ST_E_RV: begin
          pu    <= q_par;
          lu    <= q_lvl;
          state <= ST_E_CAP;
        end
        ST_E_CAP: begin
          pv <= q_par;
          lv <= q_lvl;
          case (phase)
            PH_INIT: state <= ST_E_TREE;
            PH_V:    state <= ST_E_LVL2;
            default: state <= ST_E_LOOP;
          endcase
        end
        ST_E_TREE: begin
          // Tree edge check, then the deeper second endpoint steps up once.
          if (is_tree) begin
            res_tree <= 1'b1;
            state    <= ST_EMIT;
          end else if (lu < lv) begin
            v     <= pv;
            phase <= PH_V;
            state <= ST_E_RU;
          end else begin
            state <= ST_E_LVL2;
          end
        end
        ST_E_LVL2: begin
          // The deeper first endpoint steps up once.
          phase <= PH_LOOP;
          if (lv < lu) begin
            u     <= pu;
            state <= ST_E_RU;
          end else begin
            state <= ST_E_LOOP;
          end
        end
        ST_E_LOOP: begin
          state <= climb ? ST_E_MV : ST_E_FIN;
        end
        ST_E_MV: begin
          // One lockstep step up on both sides.
          u     <= pu;
          v     <= pv;
          steps <= steps + 1'b1;
          state <= ST_E_RU;
        end
        ST_E_FIN: begin
          res_ca <= pu;
          res_bf <= u;
          res_bs <= v;
          state  <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hand the result to the output register once it is free.
          if (!out_valid || rsp.ready) begin
            out_data.tree_edge       <= res_tree;
            out_data.bridge_flag     <= res_bridge;
            out_data.parent_out      <= res_par;
            out_data.common_ancestor <= res_ca;
            out_data.base_first      <= res_bf;
            out_data.base_second     <= res_bs;
            out_valid                <= 1'b1;
            state                    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/spanning_tree_bridge_marker_core_test.sv @@
`default_nettype none

module spanning_tree_bridge_marker_core_test import stbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV          = MAX_VERTICES_DEFAULT;
  localparam int RANDOM_CMDS = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stbm_cmd_if cmd_ch ();
  stbm_rsp_if rsp_ch ();

  spanning_tree_bridge_marker_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Items waiting to be sent and results waiting to be seen.
  stbm_cmd_t pending_cmds [$];
  stbm_rsp_t expected_rsps [$];

  // Predicted copy of the tree memory and the cycle marks.
  logic [VW-1:0] tree_parent  [NV];
  logic [LW-1:0] tree_level   [NV];
  logic          cycle_marked [NV];

  // Stimulus bookkeeping: which vertices hold data and what tree is being built.
  bit gen_loaded [NV];
  bit in_phase   [NV];
  int gen_parent [NV];
  int gen_level  [NV];
  int loaded_list [$];
  int members [$];

  int error_count = 0;
  int cycle_count = 0;
  int rsp_count   = 0;
  int drv_gap     = 0;
  int mon_gap     = 0;
  int n_loads = 0, n_links = 0, n_queries = 0, n_nops = 0;
  int n_tree_links = 0, n_bridges = 0;

  // Every input starts at a known value.
  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    tree_parent  = '{default: '0};
    tree_level   = '{default: '0};
    cycle_marked = '{default: 1'b0};
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", rsp_count, name, got, want));
  endtask

  // Idling is allowed in stretches, and not at all near the end of the stimulus.
  function automatic bit idle_allowed();
    return pending_cmds.size() > 60 && (pending_cmds.size() % 100) >= 30;
  endfunction

  // Predicts the result of one item and updates the predicted tree state.
  task automatic predict_marker_result(input stbm_cmd_t c, output stbm_rsp_t r);
    logic [VW-1:0] u;
    logic [VW-1:0] v;
    int steps;
    r = '0;
    u = c.vertex_a;
    v = c.vertex_b;
    case (c.operation)
      OP_LOAD: begin
        tree_parent[u]  = c.parent_in;
        tree_level[u]   = c.level_in;
        cycle_marked[u] = 1'b0;
      end
      OP_EDGE: begin
        if (tree_parent[u] == v || tree_parent[v] == u) begin
          r.tree_edge = 1'b1;
        end else begin
          // The deeper endpoint steps up once, then both climb together.
          if (tree_level[u] < tree_level[v]) begin
            cycle_marked[v] = 1'b1;
            v = tree_parent[v];
          end
          if (tree_level[v] < tree_level[u]) begin
            cycle_marked[u] = 1'b1;
            u = tree_parent[u];
          end
          steps = 0;
          while (tree_parent[u] != tree_parent[v] && steps < CLIMB_LIMIT) begin
            cycle_marked[u] = 1'b1;
            cycle_marked[v] = 1'b1;
            u = tree_parent[u];
            v = tree_parent[v];
            steps++;
          end
          cycle_marked[u]   = 1'b1;
          cycle_marked[v]   = 1'b1;
          r.common_ancestor = tree_parent[u];
          r.base_first      = u;
          r.base_second     = v;
        end
      end
      OP_QUERY: begin
        r.bridge_flag = (tree_parent[u] != u) && !cycle_marked[u];
        r.parent_out  = tree_parent[u];
      end
      default: begin
      end
    endcase
  endtask

  // Appends one item to the send queue and tracks what has been loaded.
  task automatic queue_cmd(input logic [OP_W-1:0] op, input int a, input int b,
                           input int p, input int l);
    stbm_cmd_t c;
    c.operation = op;
    c.vertex_a  = a[VW-1:0];
    c.vertex_b  = b[VW-1:0];
    c.parent_in = p[VW-1:0];
    c.level_in  = l[LW-1:0];
    pending_cmds.insert(pending_cmds.size(), c);
    if (op == OP_LOAD) begin
      if (!gen_loaded[a])
        loaded_list.insert(loaded_list.size(), a);
      gen_loaded[a] = 1'b1;
      gen_parent[a] = p;
      gen_level[a]  = l;
    end
  endtask

  function automatic int pick_outside_phase();
    int v;
    v = $urandom_range(0, NV - 1);
    while (in_phase[v])
      v = $urandom_range(0, NV - 1);
    return v;
  endfunction

  function automatic int rnd();
    return $urandom_range(0, NV - 1);
  endfunction

  // Driver: offers the next pending item, with random gaps.
  always @(posedge clk) begin
    stbm_rsp_t r;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_marker_result(cmd_ch.data, r);
        expected_rsps.insert(expected_rsps.size(), r);
        case (cmd_ch.data.operation)
          OP_LOAD:  n_loads++;
          OP_EDGE:  n_links++;
          OP_QUERY: n_queries++;
          default:  n_nops++;
        endcase
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          cmd_ch.valid <= 1'b0;
        end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
          drv_gap = $urandom_range(0, 5);
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data  <= pending_cmds.pop_front();
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, with random stalls.
  always @(posedge clk) begin
    stbm_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      mon_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_count));
        end else begin
          want = expected_rsps.pop_front();
          check_field("tree_edge", int'(rsp_ch.data.tree_edge), int'(want.tree_edge));
          check_field("bridge_flag", int'(rsp_ch.data.bridge_flag),
                      int'(want.bridge_flag));
          check_field("parent_out", int'(rsp_ch.data.parent_out), int'(want.parent_out));
          check_field("common_ancestor", int'(rsp_ch.data.common_ancestor),
                      int'(want.common_ancestor));
          check_field("base_first", int'(rsp_ch.data.base_first), int'(want.base_first));
          check_field("base_second", int'(rsp_ch.data.base_second),
                      int'(want.base_second));
          if (want.tree_edge)
            n_tree_links++;
          if (want.bridge_flag)
            n_bridges++;
        end
        rsp_count++;
      end
      if (mon_gap > 0) begin
        mon_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 4) == 0) begin
        mon_gap = $urandom_range(0, 5);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus generation, reset, and end of run.
  initial begin
    int n_directed;
    int n;
    int m;
    int v;
    int p;
    int a;
    int b;
    int sel;

    // Directed part: a small tree over the extreme vertex numbers.
    queue_cmd(OP_LOAD, 0, rnd(), 0, 0);
    queue_cmd(OP_LOAD, 1023, rnd(), 0, 1);
    queue_cmd(OP_LOAD, 512, rnd(), 1023, 2);
    queue_cmd(OP_LOAD, 341, rnd(), 0, 1);
    queue_cmd(OP_LOAD, 682, rnd(), 341, 2);
    queue_cmd(OP_QUERY, 0, rnd(), rnd(), rnd());
    queue_cmd(OP_QUERY, 1023, rnd(), rnd(), rnd());
    queue_cmd(OP_QUERY, 512, rnd(), rnd(), rnd());
    // Tree edges in both orders, then non-tree edges at equal and unequal levels.
    queue_cmd(OP_EDGE, 0, 1023, rnd(), rnd());
    queue_cmd(OP_EDGE, 1023, 0, rnd(), rnd());
    queue_cmd(OP_EDGE, 512, 682, rnd(), rnd());
    queue_cmd(OP_EDGE, 512, 341, rnd(), rnd());
    queue_cmd(OP_EDGE, 682, 682, rnd(), rnd());
    queue_cmd(OP_QUERY, 1023, rnd(), rnd(), rnd());
    queue_cmd(OP_QUERY, 682, rnd(), rnd(), rnd());
    // Reloading a vertex clears its mark.
    queue_cmd(OP_LOAD, 1023, rnd(), 0, 1);
    queue_cmd(OP_QUERY, 1023, rnd(), rnd(), rnd());
    // The unused operation with all fields high and all fields low.
    queue_cmd(OP_NOP, 1023, 1023, 1023, 1023);
    queue_cmd(OP_NOP, 0, 0, 0, 0);
    // A vertex with the largest level hung under the largest vertex number.
    queue_cmd(OP_LOAD, 777, rnd(), 1023, 1023);
    queue_cmd(OP_EDGE, 777, 682, rnd(), rnd());
    queue_cmd(OP_QUERY, 777, rnd(), rnd(), rnd());
    // Malformed tree: two separate roots, so the climb runs out its step limit.
    queue_cmd(OP_LOAD, 100, rnd(), 100, 0);
    queue_cmd(OP_EDGE, 100, 0, rnd(), rnd());
    queue_cmd(OP_QUERY, 100, rnd(), rnd(), rnd());
    n_directed = pending_cmds.size();

    // Random part: build a fresh tree, then work on it with edges and queries.
    while (pending_cmds.size() - n_directed < RANDOM_CMDS) begin
      foreach (members[i])
        in_phase[members[i]] = 1'b0;
      members.delete();
      n = $urandom_range(4, 30);
      v = pick_outside_phase();
      queue_cmd(OP_LOAD, v, rnd(), v, 0);
      members.insert(members.size(), v);
      in_phase[v] = 1'b1;
      for (int i = 1; i < n; i++) begin
        v = pick_outside_phase();
        if ($urandom_range(0, 1) == 1)
          p = members[members.size() - 1];
        else
          p = members[$urandom_range(0, members.size() - 1)];
        queue_cmd(OP_LOAD, v, rnd(), p, gen_level[p] + 1);
        members.insert(members.size(), v);
        in_phase[v] = 1'b1;
      end
      m = $urandom_range(10, 40);
      repeat (m) begin
        sel = $urandom_range(0, 99);
        a = members[$urandom_range(0, members.size() - 1)];
        b = members[$urandom_range(0, members.size() - 1)];
        if (sel < 45) begin
          queue_cmd(OP_EDGE, a, b, rnd(), rnd());
        end else if (sel < 60) begin
          // An edge that is in the tree, in either order.
          a = members[$urandom_range(1, members.size() - 1)];
          b = gen_parent[a];
          if ($urandom_range(0, 1) == 1)
            queue_cmd(OP_EDGE, a, b, rnd(), rnd());
          else
            queue_cmd(OP_EDGE, b, a, rnd(), rnd());
        end else if (sel < 80) begin
          queue_cmd(OP_QUERY, a, rnd(), rnd(), rnd());
        end else if (sel < 87) begin
          a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          queue_cmd(OP_QUERY, a, rnd(), rnd(), rnd());
        end else if (sel < 92) begin
          queue_cmd(OP_NOP, rnd(), rnd(), rnd(), rnd());
        end else if (sel < 97) begin
          // A leaf with an arbitrary level under a vertex of this tree.
          v = pick_outside_phase();
          queue_cmd(OP_LOAD, v, rnd(), a, rnd());
          members.insert(members.size(), v);
          in_phase[v] = 1'b1;
        end else begin
          queue_cmd(OP_EDGE, a, a, rnd(), rnd());
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item to go in and every result to come out.
    while (pending_cmds.size() != 0 || cmd_ch.valid)
      @(posedge clk);
    while (expected_rsps.size() != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d loads, %0d edge items (%0d tree edges),", n_loads, n_links,
             n_tree_links);
    $display("%0d queries (%0d bridges), %0d no-ops; checked %0d results in %0d cycles.",
             n_queries, n_bridges, n_nops, rsp_count, cycle_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ spanning_tree_bridge_marker_core.f @@
rtl/stbm_pkg.sv
rtl/stbm_if.sv
rtl/spanning_tree_bridge_marker_core.sv
test/spanning_tree_bridge_marker_core_test.sv
